// ===== src/accumulator_alu_with_flags_core_defines.svh =====
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags_core_defines.svh
// Assertion macros shared by the ALU core.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_CORE_DEFINES_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_CORE_DEFINES_SVH

// Check on every edge once out of reset.
`define ALUF_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every edge, reset included.
`define ALUF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/aluf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aluf_pkg
// Word types and operation codes for the accumulator ALU.
// ----------------------------------------------------------------------------
package aluf_pkg;

    typedef logic [4:0] func_t;

    localparam func_t FN_ADD = 5'd0;
    localparam func_t FN_ADC = 5'd1;
    localparam func_t FN_SUB = 5'd2;
    localparam func_t FN_SBB = 5'd3;
    localparam func_t FN_AND = 5'd4;
    localparam func_t FN_XOR = 5'd5;
    localparam func_t FN_OR  = 5'd6;
    localparam func_t FN_CMP = 5'd7;
    localparam func_t FN_INR = 5'd8;
    localparam func_t FN_DCR = 5'd9;
    localparam func_t FN_DAA = 5'd10;
    localparam func_t FN_CMA = 5'd11;
    localparam func_t FN_STC = 5'd12;
    localparam func_t FN_CMC = 5'd13;
    localparam func_t FN_RLC = 5'd14;
    localparam func_t FN_RRC = 5'd15;
    localparam func_t FN_RAL = 5'd16;
    localparam func_t FN_RAR = 5'd17;

    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;

    typedef struct packed {
        func_t      func;
        logic [7:0] acc_in;
        logic [7:0] operand;
        logic       carry_in;
        logic       aux_carry_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] result;
        logic       carry_out;
        logic       aux_carry_out;
        logic       parity_out;
        logic       zero_out;
        logic       sign_out;
    } out_word_t;

endpackage

// ===== src/aluf_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aluf_in_stage
// Input register: captures one operation word and holds it for the ALU.
// ----------------------------------------------------------------------------
module aluf_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  aluf_pkg::in_word_t s_word,
    input  logic               dn_ready,
    output logic               dn_valid,
    output aluf_pkg::in_word_t dn_word
);
    import aluf_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    // Take a new word whenever the held one leaves or the stage is empty.
    assign s_ready    = !valid_reg || dn_ready;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

// ===== src/aluf_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aluf_calc
// Combinational ALU: result byte and the five flags from one operation word.
// ----------------------------------------------------------------------------
module aluf_calc (
    input  aluf_pkg::in_word_t  op_word,
    output aluf_pkg::out_word_t res_word
);
    import aluf_pkg::*;

    logic [7:0] a;
    logic [7:0] b;
    logic       ci;
    logic       ai;
    logic       bin;
    logic [8:0] sum9;
    logic [4:0] add_nib;
    logic [8:0] diff9;
    logic [4:0] sub_nib;
    logic       lo_fix;
    logic       hi_fix;
    logic [7:0] corr;
    logic [4:0] daa_nib;
    logic [7:0] r;
    logic [7:0] basis;
    logic       cy;
    logic       ac;
    logic       pzs;

    assign a  = op_word.acc_in;
    assign b  = op_word.operand;
    assign ci = op_word.carry_in;
    assign ai = op_word.aux_carry_in;

    // Borrow or carry only for the with-carry forms.
    assign bin = (op_word.func == FN_ADC || op_word.func == FN_SBB) ? ci : 1'b0;

    assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, bin};
    assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, bin};
    assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, bin};
    assign sub_nib = {1'b0, a[3:0]} + {1'b0, ~b[3:0]} + {4'd0, ~bin};

    assign lo_fix  = (a[3:0] > DAA_LO_LIMIT) || ai;
    assign hi_fix  = (a > DAA_HI_LIMIT) || ci;
    assign corr    = (lo_fix ? DAA_LO_ADJ : 8'h00) | (hi_fix ? DAA_HI_ADJ : 8'h00);
    assign daa_nib = {1'b0, a[3:0]} + {1'b0, corr[3:0]};

    always_comb begin
        r     = a;
        basis = 8'h00;
        cy    = ci;
        ac    = ai;
        pzs   = 1'b0;
        case (op_word.func)
            FN_ADD, FN_ADC: begin
                r     = sum9[7:0];
                basis = sum9[7:0];
                cy    = sum9[8];
                ac    = add_nib[4];
                pzs   = 1'b1;
            end
            FN_SUB, FN_SBB, FN_CMP: begin
                // Compare keeps the accumulator; flags follow the difference.
                r     = (op_word.func == FN_CMP) ? a : diff9[7:0];
                basis = diff9[7:0];
                cy    = diff9[8];
                ac    = sub_nib[4];
                pzs   = 1'b1;
            end
            FN_AND: begin
                r     = a & b;
                basis = a & b;
                cy    = 1'b0;
                ac    = 1'b1;
                pzs   = 1'b1;
            end
            FN_XOR: begin
                r     = a ^ b;
                basis = a ^ b;
                cy    = 1'b0;
                ac    = 1'b0;
                pzs   = 1'b1;
            end
            FN_OR: begin
                r     = a | b;
                basis = a | b;
                cy    = 1'b0;
                ac    = 1'b0;
                pzs   = 1'b1;
            end
            FN_INR: begin
                r     = a + 8'd1;
                basis = a + 8'd1;
                ac    = (a[3:0] == 4'hF);
                pzs   = 1'b1;
            end
            FN_DCR: begin
                r     = a - 8'd1;
                basis = a - 8'd1;
                ac    = (a[3:0] != 4'h0);
                pzs   = 1'b1;
            end
            FN_DAA: begin
                r     = a + corr;
                basis = a + corr;
                cy    = hi_fix;
                ac    = daa_nib[4];
                pzs   = 1'b1;
            end
            FN_CMA: r = ~a;
            FN_STC: cy = 1'b1;
            FN_CMC: cy = ~ci;
            FN_RLC: begin
                r  = {a[6:0], a[7]};
                cy = a[7];
            end
            FN_RRC: begin
                r  = {a[0], a[7:1]};
                cy = a[0];
            end
            FN_RAL: begin
                r  = {a[6:0], ci};
                cy = a[7];
            end
            FN_RAR: begin
                r  = {ci, a[7:1]};
                cy = a[0];
            end
            default: begin
                // Unused codes pass the accumulator, carry and aux carry through; parity, zero and sign read zero.
                r = a;
            end
        endcase
    end

    // Fields in order: result, carry, aux carry, parity, zero, sign
    assign res_word = {r, cy, ac, pzs & ~(^basis), pzs & (basis == 8'h00), pzs & basis[7]};

endmodule

// ===== src/accumulator_alu_with_flags_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags_core
// Eight-bit accumulator ALU with carry, parity, aux carry, zero and sign flags.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one operation word per accepted handshake: the
//   operation code, the accumulator, the operand byte and the incoming carry
//   and aux carry. The m_ channel returns one result word for each: the new
//   byte and five flags. Both sides use valid/ready.
//   From input accept to m_valid a word passes one input register, the ALU
//   logic and one result register.
//   Throughput is one word per cycle while m_ready stays high; the single pass
//   through the ALU logic between the two registers sets that figure.
//   When the receiver stalls, the result register holds its word and the
//   input register can still take one more word; s_ready drops only when
//   both registers are full.
//   A synchronous low aresetn empties both registers; no result is shown
//   until new words arrive. The block keeps no state between words.
// ----------------------------------------------------------------------------
`include "accumulator_alu_with_flags_core_defines.svh"

module accumulator_alu_with_flags_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [4:0] s_func,
    input  logic [7:0] s_acc_in,
    input  logic [7:0] s_operand,
    input  logic       s_carry_in,
    input  logic       s_aux_carry_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result,
    output logic       m_carry_out,
    output logic       m_aux_carry_out,
    output logic       m_parity_out,
    output logic       m_zero_out,
    output logic       m_sign_out
);
    import aluf_pkg::*;

    in_word_t  s_word;
    in_word_t  op_word;
    out_word_t res_word;
    logic      mid_valid;
    logic      mid_ready;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;

    assign s_word = {s_func, s_acc_in, s_operand, s_carry_in, s_aux_carry_in};

    aluf_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .dn_ready (mid_ready),
        .dn_valid (mid_valid),
        .dn_word  (op_word)
    );

    aluf_calc u_calc (
        .op_word  (op_word),
        .res_word (res_word)
    );

    // Result register advances when empty or when its word is taken.
    assign mid_ready      = !out_valid_reg || m_ready;
    assign out_valid_next = mid_ready ? mid_valid : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_valid && mid_ready) begin
            out_word_reg <= res_word;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result        = out_word_reg.result;
    assign m_carry_out     = out_word_reg.carry_out;
    assign m_aux_carry_out = out_word_reg.aux_carry_out;
    assign m_parity_out    = out_word_reg.parity_out;
    assign m_zero_out      = out_word_reg.zero_out;
    assign m_sign_out      = out_word_reg.sign_out;

    `ALUF_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid && s_ready, "reset left a word held")
    `ALUF_ASSERT_CLK(a_mid_moves, mid_valid && mid_ready |=> m_valid, "ALU word not registered")
    `ALUF_ASSERT_CLK(a_full_stall, !s_ready |-> mid_valid && m_valid && !m_ready, "input blocked while space left")
    `ALUF_ASSERT_CLK(a_zero_flags, m_valid && m_zero_out |-> m_parity_out && !m_sign_out, "zero flag disagrees with parity or sign")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the accumulator ALU core.
// ----------------------------------------------------------------------------
// A short table of hand-picked operation words comes first: extremes, every
// operation code, unused codes and the decimal adjust corners. Some rows carry
// a hand-written result and the rest are scored by a local model of the ALU.
// About 650 random words follow, sent in bursts with random gaps while the
// result side stalls on a rotating pattern. Two long receiver hold-offs
// back the core up until it stops taking input. Every result word is compared
// field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module tb_top;
    import aluf_pkg::*;

    localparam func_t FN_UNUSED_LO = 5'd18;
    localparam func_t FN_UNUSED_HI = 5'd31;
    localparam int    RAND_WORDS   = 650;
    localparam int    HOLD_CYCLES  = 60;

    typedef struct packed {
        in_word_t  w;
        logic      typed;
        out_word_t want;
    } op_row_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [4:0] s_func         = '0;
    logic [7:0] s_acc_in       = '0;
    logic [7:0] s_operand      = '0;
    logic       s_carry_in     = 1'b0;
    logic       s_aux_carry_in = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_result;
    logic       m_carry_out;
    logic       m_aux_carry_out;
    logic       m_parity_out;
    logic       m_zero_out;
    logic       m_sign_out;

    // Side info that travels with the word on the input port
    logic       pin_typed = 1'b0;
    out_word_t  pin_want  = '0;

    out_word_t  flags_q[$];
    op_row_t    op_table[$];
    int         err_cnt     = 0;
    int         words_in    = 0;
    int         words_out   = 0;
    logic [31:0] codes_seen = '0;

    accumulator_alu_with_flags_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_acc_in        (s_acc_in),
        .s_operand       (s_operand),
        .s_carry_in      (s_carry_in),
        .s_aux_carry_in  (s_aux_carry_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result        (m_result),
        .m_carry_out     (m_carry_out),
        .m_aux_carry_out (m_aux_carry_out),
        .m_parity_out    (m_parity_out),
        .m_zero_out      (m_zero_out),
        .m_sign_out      (m_sign_out)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("[accumulator_alu_with_flags_core] ERROR");
        $finish;
    end

    function automatic out_word_t alu_flags(in_word_t w);
        out_word_t  o;
        logic [8:0] sum;
        logic [4:0] lo;
        logic [7:0] basis;
        logic [7:0] adj;
        logic       cin;
        logic       pzs;
        o.result        = w.acc_in;
        o.carry_out     = w.carry_in;
        o.aux_carry_out = w.aux_carry_in;
        pzs   = 1'b0;
        basis = 8'h00;
        case (w.func)
            FN_ADD, FN_ADC: begin
                cin             = (w.func == FN_ADC) & w.carry_in;
                sum             = {1'b0, w.acc_in} + {1'b0, w.operand} + {8'b0, cin};
                lo              = {1'b0, w.acc_in[3:0]} + {1'b0, w.operand[3:0]} + {4'b0, cin};
                o.result        = sum[7:0];
                o.carry_out     = sum[8];
                o.aux_carry_out = lo[4];
                pzs             = 1'b1;
                basis           = sum[7:0];
            end
            FN_SUB, FN_SBB, FN_CMP: begin
                cin             = (w.func == FN_SBB) & w.carry_in;
                // bit 8 of the 9-bit difference is the borrow
                sum             = {1'b0, w.acc_in} - {1'b0, w.operand} - {8'b0, cin};
                lo              = {1'b0, w.acc_in[3:0]} + {1'b0, ~w.operand[3:0]} + {4'b0, ~cin};
                o.result        = (w.func == FN_CMP) ? w.acc_in : sum[7:0];
                o.carry_out     = sum[8];
                o.aux_carry_out = lo[4];
                pzs             = 1'b1;
                basis           = sum[7:0];
            end
            FN_AND, FN_XOR, FN_OR: begin
                if (w.func == FN_AND) begin
                    o.result = w.acc_in & w.operand;
                end else if (w.func == FN_XOR) begin
                    o.result = w.acc_in ^ w.operand;
                end else begin
                    o.result = w.acc_in | w.operand;
                end
                o.carry_out     = 1'b0;
                o.aux_carry_out = (w.func == FN_AND);
                pzs             = 1'b1;
                basis           = o.result;
            end
            FN_INR: begin
                o.result        = w.acc_in + 8'd1;
                o.aux_carry_out = (w.acc_in[3:0] == 4'hF);
                pzs             = 1'b1;
                basis           = o.result;
            end
            FN_DCR: begin
                o.result        = w.acc_in - 8'd1;
                o.aux_carry_out = (w.acc_in[3:0] != 4'h0);
                pzs             = 1'b1;
                basis           = o.result;
            end
            FN_DAA: begin
                adj         = 8'h00;
                o.carry_out = 1'b0;
                if (w.acc_in[3:0] > DAA_LO_LIMIT || w.aux_carry_in) begin
                    adj = adj | DAA_LO_ADJ;
                end
                if (w.acc_in > DAA_HI_LIMIT || w.carry_in) begin
                    adj         = adj | DAA_HI_ADJ;
                    o.carry_out = 1'b1;
                end
                o.result        = w.acc_in + adj;
                lo              = {1'b0, w.acc_in[3:0]} + {1'b0, adj[3:0]};
                o.aux_carry_out = lo[4];
                pzs             = 1'b1;
                basis           = o.result;
            end
            FN_CMA: o.result = ~w.acc_in;
            FN_STC: o.carry_out = 1'b1;
            FN_CMC: o.carry_out = ~w.carry_in;
            FN_RLC: begin
                o.result    = {w.acc_in[6:0], w.acc_in[7]};
                o.carry_out = w.acc_in[7];
            end
            FN_RRC: begin
                o.result    = {w.acc_in[0], w.acc_in[7:1]};
                o.carry_out = w.acc_in[0];
            end
            FN_RAL: begin
                o.result    = {w.acc_in[6:0], w.carry_in};
                o.carry_out = w.acc_in[7];
            end
            FN_RAR: begin
                o.result    = {w.carry_in, w.acc_in[7:1]};
                o.carry_out = w.acc_in[0];
            end
            default: ;
        endcase
        o.parity_out = pzs & ~(^basis);
        o.zero_out   = pzs & (basis == 8'h00);
        o.sign_out   = pzs & basis[7];
        return o;
    endfunction

    task automatic cmp_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    task automatic score_result();
        out_word_t want;
        if (flags_q.size() == 0) begin
            $error("result word 0x%0h with nothing expected", m_result);
            err_cnt++;
        end else begin
            want = flags_q.pop_front();
            cmp_field("result", 32'(want.result), 32'(m_result));
            cmp_field("carry_out", 32'(want.carry_out), 32'(m_carry_out));
            cmp_field("aux_carry_out", 32'(want.aux_carry_out), 32'(m_aux_carry_out));
            cmp_field("parity_out", 32'(want.parity_out), 32'(m_parity_out));
            cmp_field("zero_out", 32'(want.zero_out), 32'(m_zero_out));
            cmp_field("sign_out", 32'(want.sign_out), 32'(m_sign_out));
        end
        words_out++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                flags_q.push_back(pin_typed ? pin_want :
                    alu_flags({s_func, s_acc_in, s_operand, s_carry_in, s_aux_carry_in}));
                codes_seen[s_func] <= 1'b1;
                words_in++;
            end
            if (m_valid && m_ready) begin
                score_result();
            end
        end
    end

    // Result side: rotate through stall patterns, with two long hold-offs
    initial begin
        int cyc;
        int hold;
        cyc  = 0;
        hold = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc == 300 || cyc == 1100) begin
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                case ((cyc / 80) % 4)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(1, 0));
                    2: m_ready <= ($urandom_range(3, 0) == 0);
                    default: m_ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3, 0) != 0) begin
            return 8'($urandom_range(255, 0));
        end
        case ($urandom_range(7, 0))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h0F;
            3: return 8'hF0;
            4: return 8'h99;
            5: return 8'h9A;
            6: return 8'h80;
            default: return 8'h7F;
        endcase
    endfunction

    // Hand-written results are packed as {result, carry, aux, parity, zero, sign}
    task automatic add_row(func_t f, logic [7:0] a, logic [7:0] b, logic c, logic ac,
                           logic typed, out_word_t want);
        op_row_t row;
        row.w     = {f, a, b, c, ac};
        row.typed = typed;
        row.want  = want;
        op_table.push_back(row);
    endtask

    int burst_left = 0;

    task automatic send_word(in_word_t w, logic typed, out_word_t want);
        int gap;
        s_valid        <= 1'b1;
        s_func         <= w.func;
        s_acc_in       <= w.acc_in;
        s_operand      <= w.operand;
        s_carry_in     <= w.carry_in;
        s_aux_carry_in <= w.aux_carry_in;
        pin_typed      <= typed;
        pin_want       <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // end of burst: drop valid for a random gap
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(24, 1);
            gap        = $urandom_range(2, 0) == 0 ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin
        in_word_t w;
        add_row(FN_ADD, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, {8'h00, 5'b00110});
        add_row(FN_ADD, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, {8'hFE, 5'b11001});
        add_row(FN_ADC, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1, {8'hFF, 5'b11101});
        add_row(FN_ADC, 8'h0F, 8'h00, 1'b1, 1'b0, 1'b0, '0);
        add_row(FN_SUB, 8'h00, 8'h01, 1'b1, 1'b1, 1'b1, {8'hFF, 5'b10101});
        add_row(FN_SBB, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1, {8'h00, 5'b10110});
        add_row(FN_SBB, 8'h10, 8'h0F, 1'b1, 1'b1, 1'b0, '0);
        add_row(FN_CMP, 8'h5A, 8'h5A, 1'b1, 1'b0, 1'b1, {8'h5A, 5'b01110});
        add_row(FN_AND, 8'hFF, 8'h0F, 1'b1, 1'b0, 1'b1, {8'h0F, 5'b01100});
        add_row(FN_XOR, 8'hAA, 8'hAA, 1'b1, 1'b1, 1'b1, {8'h00, 5'b00110});
        add_row(FN_OR,  8'h80, 8'h01, 1'b1, 1'b1, 1'b1, {8'h81, 5'b00101});
        add_row(FN_INR, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b1, {8'h00, 5'b11110});
        add_row(FN_DCR, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b1, {8'hFF, 5'b00101});
        add_row(FN_DAA, 8'h9A, 8'h00, 1'b0, 1'b0, 1'b1, {8'h00, 5'b11110});
        add_row(FN_DAA, 8'h99, 8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(FN_DAA, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0);
        add_row(FN_CMA, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, {8'hFF, 5'b10000});
        add_row(FN_STC, 8'h3C, 8'h00, 1'b0, 1'b1, 1'b1, {8'h3C, 5'b11000});
        add_row(FN_CMC, 8'h3C, 8'h00, 1'b1, 1'b0, 1'b1, {8'h3C, 5'b00000});
        add_row(FN_RLC, 8'h80, 8'h00, 1'b0, 1'b1, 1'b1, {8'h01, 5'b11000});
        add_row(FN_RRC, 8'h01, 8'h00, 1'b0, 1'b0, 1'b1, {8'h80, 5'b10000});
        add_row(FN_RAL, 8'h80, 8'h00, 1'b0, 1'b0, 1'b1, {8'h00, 5'b10000});
        add_row(FN_RAR, 8'h01, 8'h00, 1'b1, 1'b1, 1'b1, {8'h80, 5'b11000});
        add_row(FN_UNUSED_LO, 8'h55, 8'hFF, 1'b1, 1'b0, 1'b1, {8'h55, 5'b10000});
        add_row(FN_UNUSED_HI, 8'hAA, 8'hFF, 1'b0, 1'b1, 1'b1, {8'hAA, 5'b01000});

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        foreach (op_table[i]) begin
            send_word(op_table[i].w, op_table[i].typed, op_table[i].want);
        end

        for (int n = 0; n < RAND_WORDS; n++) begin
            w.func = ($urandom_range(9, 0) == 0) ? func_t'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO))
                                                 : func_t'($urandom_range(FN_RAR, FN_ADD));
            w.acc_in       = pick_byte();
            w.operand      = pick_byte();
            w.carry_in     = 1'($urandom_range(1, 0));
            w.aux_carry_in = 1'($urandom_range(1, 0));
            send_word(w, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (flags_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d words in, %0d results scored; %0d of 32 operation codes exercised",
                 words_in, words_out, $countones(codes_seen));
        $display("sender ran in bursts, receiver rotated stall patterns with two long hold-offs");
        if (err_cnt == 0) begin
            $display("[accumulator_alu_with_flags_core] OK");
        end else begin
            $display("[accumulator_alu_with_flags_core] ERROR");
        end
        $finish;
    end

endmodule
